>>> src/pmt_pkg.sv
// Shared types and constants for the primer melting temperature block.
// No dependencies; imported by every module of the block.
package pmt_pkg;

    localparam int CntW = 16;
    localparam int TmW  = 19;
    localparam int StW  = 2;

    localparam logic [CntW-1:0] MAX_LEN     = 16'd65535;
    localparam logic [CntW-1:0] SHORT_LIMIT = 16'd14;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_N = 8'h4E;

    localparam logic [StW-1:0] ST_OK      = 2'd0;
    localparam logic [StW-1:0] ST_INVALID = 2'd1;
    localparam logic [StW-1:0] ST_EMPTY   = 2'd2;
    localparam logic [StW-1:0] ST_LONG    = 2'd3;

    // Fixed-point constants of the long formula (tenths scaled)
    localparam logic [9:0]  K_BASE = 10'd649;
    localparam logic [9:0]  K_GC   = 10'd410;
    localparam logic [12:0] K_OFS  = 13'd6724;
    localparam logic [3:0]  K_DEN  = 4'd10;

    localparam int MagW  = 27;
    localparam int RemW  = 36;
    localparam int QuotW = 18;
    localparam int DivW  = 38;
    localparam int DenW  = 20;

    typedef struct packed {
        logic            divide;
        logic [StW-1:0]  status;
        logic [CntW-1:0] at;
        logic [CntW-1:0] gc;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    typedef struct packed {
        logic full;
        logic not_empty;
        job_t head;
    } queue_stat_t;

endpackage

>>> src/primer_melting_temperature.sv
// Top level of the primer melting temperature block.
// Depends on pmt_pkg, pmt_front, pmt_queue and pmt_back.
//
//  channel | direction | tdata                          | tlast
//  s_      | in        | [7:0] base_char                | last
//  m_      | out       | [18:0] tm, [20:19] status      | -
//
//  The front takes one base per cycle while the two-entry job queue has room.
//  Short, invalid, too-long and empty sequences skip the divider: the back end
//  goes from idle straight to the output state. A long sequence runs setup,
//  then 18 steps of the restoring divider, then the result register load.
//  Reset (aresetn low, synchronous) clears counts, queue and result valid.
//  A stalled result holds in the output register; the back end then halts
//  and the front stalls once the queue is full.
module primer_melting_temperature (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] base_char
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [18:0] tm, [20:19] status, [23:21] zero
);
    import pmt_pkg::*;

    push_t       push;
    queue_stat_t stat;
    logic        pop;

    pmt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (stat.full),
        .push     (push)
    );

    pmt_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .stat    (stat)
    );

    pmt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stat     (stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> src/pmt_front.sv
// Front end: accepts bases, keeps the running counts and flags.
// Pushes one job per sequence into the queue. Depends on pmt_pkg.
module pmt_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] base_char
    input  logic                 s_tlast,   // last
    input  logic                 q_full,
    output pmt_pkg::push_t       push
);
    import pmt_pkg::*;

    logic [CntW-1:0] at_reg, at_next;
    logic [CntW-1:0] gc_reg, gc_next;
    logic [CntW-1:0] len_reg, len_next;
    logic            bad_reg, bad_next;
    logic            ovf_reg, ovf_next;
    logic            accept;
    logic [CntW-1:0] sum;
    logic            long_seq;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        at_next  = at_reg;
        gc_next  = gc_reg;
        len_next = len_reg;
        bad_next = bad_reg;
        ovf_next = ovf_reg;
        if (accept) begin
            if (len_reg == MAX_LEN) begin
                ovf_next = 1'b1;
            end else begin
                len_next = len_reg + 16'd1;
                unique case (s_tdata)
                    CHAR_A, CHAR_T: at_next = at_reg + 16'd1;
                    CHAR_G, CHAR_C: gc_next = gc_reg + 16'd1;
                    CHAR_N: ;
                    default: bad_next = 1'b1;
                endcase
            end
        end
    end

    assign sum      = at_next + gc_next;
    assign long_seq = len_next >= SHORT_LIMIT;

    always_comb begin
        push.valid      = accept && s_tlast;
        push.job.divide = long_seq;
        push.job.at     = at_next;
        push.job.gc     = gc_next;
        priority if (bad_next) begin
            push.job.status = ST_INVALID;
        end else if (ovf_next) begin
            push.job.status = ST_LONG;
        end else if (long_seq && sum == '0) begin
            push.job.status = ST_EMPTY;
        end else begin
            push.job.status = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_tlast)) begin
            at_reg  <= '0;
            gc_reg  <= '0;
            len_reg <= '0;
            bad_reg <= 1'b0;
            ovf_reg <= 1'b0;
        end else begin
            at_reg  <= at_next;
            gc_reg  <= gc_next;
            len_reg <= len_next;
            bad_reg <= bad_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

>>> src/pmt_queue.sv
// Two-entry job queue between the front and back ends.
// Depends on pmt_pkg.
module pmt_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pmt_pkg::push_t       push,
    input  logic                 pop,
    output pmt_pkg::queue_stat_t stat
);
    import pmt_pkg::*;

    job_t       slot_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign do_push = push.valid && cnt_reg != 2'd2;
    assign do_pop  = pop && cnt_reg != 2'd0;

    always_comb begin
        wr_next  = do_push ? !wr_reg : wr_reg;
        rd_next  = do_pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    assign stat.full      = cnt_reg == 2'd2;
    assign stat.not_empty = cnt_reg != 2'd0;
    assign stat.head      = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_reg] <= push.job;
        end
    end

endmodule

>>> src/pmt_back.sv
// Back end: evaluates one job (Wallace rule or long formula with a
// restoring divider) and holds the result register. Depends on pmt_pkg.
module pmt_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pmt_pkg::queue_stat_t stat,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata    // [18:0] tm, [20:19] status
);
    import pmt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADJ  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [StW-1:0]   st_reg, st_next;
    logic [CntW-1:0]  s_reg, s_next;
    logic [CntW-1:0]  gc_reg, gc_next;
    logic [MagW-1:0]  prod_reg, prod_next;
    logic [DenW-1:0]  den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [RemW-1:0]  rem_reg, rem_next;
    logic [DivW-1:0]  dsh_reg, dsh_next;
    logic [QuotW-1:0] quot_reg, quot_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [TmW-1:0]   res_reg, res_next;
    logic             mv_reg, mv_next;
    logic [TmW-1:0]   mtm_reg, mtm_next;
    logic [StW-1:0]   mst_reg, mst_next;
    logic             out_free;
    logic signed [MagW:0] diff;
    logic [MagW-1:0]  mag;
    logic             fits;

    assign out_free = !mv_reg || m_tready;
    assign pop      = state_reg == S_IDLE && stat.not_empty;
    assign diff     = $signed({1'b0, prod_reg}) - $signed({15'd0, K_OFS});
    assign mag      = diff[MagW] ? MagW'(-diff) : diff[MagW-1:0];
    assign fits     = {2'b00, rem_reg} >= dsh_reg;

    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        s_next     = s_reg;
        gc_next    = gc_reg;
        prod_next  = prod_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        mv_next    = mv_reg;
        mtm_next   = mtm_reg;
        mst_next   = mst_reg;
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (stat.not_empty) begin
                    st_next = stat.head.status;
                    s_next  = stat.head.at + stat.head.gc;
                    gc_next = stat.head.gc;
                    if (stat.head.status != ST_OK) begin
                        res_next   = '0;
                        state_next = S_OUT;
                    end else if (!stat.head.divide) begin
                        res_next   = {stat.head.at[9:0], 9'd0} + {stat.head.gc[8:0], 10'd0};
                        state_next = S_OUT;
                    end else begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                prod_next  = MagW'(s_reg) * MagW'(K_BASE) + MagW'(gc_reg) * MagW'(K_GC);
                den_next   = DenW'(s_reg) * DenW'(K_DEN);
                state_next = S_ADJ;
            end
            S_ADJ: begin
                neg_next   = diff[MagW];
                rem_next   = {mag, 9'd0} + RemW'(den_reg);
                dsh_next   = {den_reg, 18'd0};
                quot_next  = '0;
                cnt_next   = 5'(QuotW - 1);
                state_next = S_DIV;
            end
            S_DIV: begin
                if (fits) begin
                    rem_next = rem_reg - dsh_reg[RemW-1:0];
                end
                quot_next = {quot_reg[QuotW-2:0], fits};
                dsh_next  = {1'b0, dsh_reg[DivW-1:1]};
                cnt_next  = cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                res_next   = neg_reg ? TmW'(-{1'b0, quot_reg}) : {1'b0, quot_reg};
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mtm_next   = res_reg;
                    mst_next   = st_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        st_reg   <= st_next;
        s_reg    <= s_next;
        gc_reg   <= gc_next;
        prod_reg <= prod_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
        mtm_reg  <= mtm_next;
        mst_reg  <= mst_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {3'd0, mst_reg, mtm_reg};

endmodule

>>> src/pmt_checker.sv
// Port-level checks for primer_melting_temperature, bound to the top level.
// Depends on the top level's port list only.
module pmt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20:19] != 2'd0 |-> m_tdata[18:0] == 19'd0)
        else $error("flagged result carries a temperature");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:21] == 3'd0)
        else $error("padding bits not zero");

endmodule

bind primer_melting_temperature pmt_checker u_pmt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
